/* hdl/ordered_queue_remove_by_key_defines.svh */
// Assertion macros for the RTL.
`ifndef ORDERED_QUEUE_REMOVE_BY_KEY_DEFINES_SVH
`define ORDERED_QUEUE_REMOVE_BY_KEY_DEFINES_SVH

`ifndef SYNTH
`define OQR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define OQR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define OQR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define OQR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/oqr_pkg.sv */
`timescale 1ns / 1ps

package oqr_pkg;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LIST   = 2'd2
  } oqr_action_t;

  typedef enum logic [2:0] {
    STAT_DONE      = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_ENTRY     = 3'd3,
    STAT_EMPTY     = 3'd4
  } oqr_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RM,
    S_LIST,
    S_RESP
  } oqr_state_t;

endpackage

/* hdl/oqr_if.sv */
`timescale 1ns / 1ps

interface oqr_in_if #(
  parameter int ID_WIDTH = 16
);
  logic                valid;
  logic                ready;
  logic [1:0]          action;
  logic [ID_WIDTH-1:0] person_id;

  modport source (output valid, output action, output person_id, input ready);
  modport sink (input valid, input action, input person_id, output ready);
endinterface

interface oqr_out_if #(
  parameter int ID_WIDTH = 16
);
  logic                valid;
  logic                ready;
  logic [2:0]          status;
  logic [ID_WIDTH-1:0] entry_id;
  logic                last;

  modport source (output valid, output status, output entry_id, output last, input ready);
  modport sink (input valid, input status, input entry_id, input last, output ready);
endinterface

/* hdl/ordered_queue_remove_by_key.sv */
`timescale 1ns / 1ps

// Ordered queue of up to DEPTH identifiers held in a single-port-write, registered-read RAM.
// Input channel in_chan: action 0 appends person_id at the tail, 1 removes the first entry
// equal to person_id and closes the gap, 2 lists every entry from head to tail; code 3 is
// dropped without a result. Result channel out_chan: status, entry_id and last, where last
// marks the final word caused by one input word.
// An append's result goes through the S_RESP state and then the output register. A remove
// makes one sequential pass over the RAM that reads one entry a cycle, compares it and
// writes it back one place lower once the key has been seen. A list gives one result a
// cycle, while the receiver takes them, after the registered RAM read of the head entry;
// an empty list or a failed append gives one status word.
// One item is worked on at a time; a new one is accepted while the last result still waits
// in the output register. When the receiver stalls, the output register holds its word and
// a list or a pending status word waits until it is taken; a remove pass does not pause.
// Reset clears the fill count and the control state; the RAM contents are not cleared and
// need no clearing pass, since only entries below the fill count are ever read.

module ordered_queue_remove_by_key #(
  parameter int DEPTH    = 32,
  parameter int ID_WIDTH = 16
) (
  input logic        clk,
  input logic        rst_n,
  oqr_in_if.sink     in_chan,
  oqr_out_if.source  out_chan
);

  localparam int AW = $clog2(DEPTH);

  logic                 emit;
  oqr_pkg::oqr_status_t emit_status;
  logic [ID_WIDTH-1:0]  emit_entry;
  logic                 emit_last;
  logic                 out_free;
  logic                 ram_wr_en;
  logic [AW-1:0]        ram_wr_addr;
  logic [ID_WIDTH-1:0]  ram_wr_data;
  logic                 ram_rd_en;
  logic [AW-1:0]        ram_rd_addr;
  logic [ID_WIDTH-1:0]  ram_rd_data;

  logic                 out_valid_r, out_valid_nxt;
  logic [2:0]           out_status_r;
  logic [ID_WIDTH-1:0]  out_entry_r;
  logic                 out_last_r;

  oqr_engine #(
    .DEPTH    (DEPTH),
    .ID_WIDTH (ID_WIDTH)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_free    (out_free),
    .emit        (emit),
    .emit_status (emit_status),
    .emit_entry  (emit_entry),
    .emit_last   (emit_last),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  oqr_ram #(
    .WIDTH (ID_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign out_free      = !out_valid_r || out_chan.ready;
  assign out_valid_nxt = emit || (out_valid_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= emit_status;
      out_entry_r  <= emit_entry;
      out_last_r   <= emit_last;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.status   = out_status_r;
  assign out_chan.entry_id = out_entry_r;
  assign out_chan.last     = out_last_r;

endmodule

/* hdl/oqr_ram.sv */
`timescale 1ns / 1ps

module oqr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/oqr_engine.sv */
`timescale 1ns / 1ps
`include "ordered_queue_remove_by_key_defines.svh"

module oqr_engine #(
  parameter int DEPTH    = 32,
  parameter int ID_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  oqr_in_if.sink                     in_chan,
  input  logic                       out_free,
  output logic                       emit,
  output oqr_pkg::oqr_status_t       emit_status,
  output logic [ID_WIDTH-1:0]        emit_entry,
  output logic                       emit_last,
  output logic                       ram_wr_en,
  output logic [$clog2(DEPTH)-1:0]   ram_wr_addr,
  output logic [ID_WIDTH-1:0]        ram_wr_data,
  output logic                       ram_rd_en,
  output logic [$clog2(DEPTH)-1:0]   ram_rd_addr,
  input  logic [ID_WIDTH-1:0]        ram_rd_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  oqr_pkg::oqr_state_t  state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic                 dv_r, dv_nxt;
  logic                 found_r, found_nxt;
  logic [ID_WIDTH-1:0]  key_r, key_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  oqr_pkg::oqr_status_t status_r, status_nxt;
  logic [CW-1:0]        idx_plus;
  logic                 list_last;

  assign idx_plus  = idx_r + CW'(1);
  assign list_last = (idx_plus == count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= oqr_pkg::S_IDLE;
      count_r <= '0;
      idx_r   <= '0;
      dv_r    <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      dv_r    <= dv_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    pos_r    <= pos_nxt;
    status_r <= status_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    dv_nxt      = dv_r;
    found_nxt   = found_r;
    key_nxt     = key_r;
    pos_nxt     = pos_r;
    status_nxt  = status_r;
    in_chan.ready = 1'b0;
    emit        = 1'b0;
    emit_status = oqr_pkg::STAT_DONE;
    emit_entry  = '0;
    emit_last   = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = '0;
    ram_wr_data = '0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = '0;

    unique case (state_r)
      oqr_pkg::S_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          unique case (oqr_pkg::oqr_action_t'(in_chan.action))
            oqr_pkg::ACT_APPEND: begin
              if (count_r == CW'(DEPTH)) begin
                status_nxt = oqr_pkg::STAT_FULL;
              end else begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = count_r[AW-1:0];
                ram_wr_data = in_chan.person_id;
                count_nxt   = count_r + CW'(1);
                status_nxt  = oqr_pkg::STAT_DONE;
              end
              state_nxt = oqr_pkg::S_RESP;
            end
            oqr_pkg::ACT_REMOVE: begin
              key_nxt   = in_chan.person_id;
              idx_nxt   = '0;
              dv_nxt    = 1'b0;
              found_nxt = 1'b0;
              state_nxt = oqr_pkg::S_RM;
            end
            oqr_pkg::ACT_LIST: begin
              if (count_r == '0) begin
                status_nxt = oqr_pkg::STAT_EMPTY;
                state_nxt  = oqr_pkg::S_RESP;
              end else begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = '0;
                idx_nxt     = '0;
                state_nxt   = oqr_pkg::S_LIST;
              end
            end
            default: begin
            end
          endcase
        end
      end

      oqr_pkg::S_RM: begin
        if (idx_r < count_r) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = idx_r[AW-1:0];
          pos_nxt     = idx_r[AW-1:0];
          idx_nxt     = idx_plus;
          dv_nxt      = 1'b1;
        end else begin
          dv_nxt = 1'b0;
        end
        // Once the key is found, every later word moves one place toward the head.
        if (dv_r) begin
          if (found_r) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_r - AW'(1);
            ram_wr_data = ram_rd_data;
          end else if (ram_rd_data == key_r) begin
            found_nxt = 1'b1;
          end
        end
        if ((idx_r == count_r) && !dv_r) begin
          if (found_r) begin
            count_nxt  = count_r - CW'(1);
            status_nxt = oqr_pkg::STAT_DONE;
          end else begin
            status_nxt = oqr_pkg::STAT_NOT_FOUND;
          end
          state_nxt = oqr_pkg::S_RESP;
        end
      end

      oqr_pkg::S_LIST: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_status = oqr_pkg::STAT_ENTRY;
          emit_entry  = ram_rd_data;
          emit_last   = list_last;
          if (list_last) begin
            state_nxt = oqr_pkg::S_IDLE;
          end else begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_plus[AW-1:0];
            idx_nxt     = idx_plus;
          end
        end
      end

      oqr_pkg::S_RESP: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_status = status_r;
          emit_last   = 1'b1;
          state_nxt   = oqr_pkg::S_IDLE;
        end
      end

      default: begin
      end
    endcase
  end

  `OQR_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(DEPTH))
  `OQR_ASSERT_NEXT(a_count_step, clk, rst_n, 1'b1, (count_r == $past(count_r)) || (count_r == $past(count_r) + CW'(1)) || (count_r == $past(count_r) - CW'(1)))
  `OQR_ASSERT_IMPL(a_list_idx, clk, rst_n, state_r == oqr_pkg::S_LIST, idx_r < count_r)
  `OQR_ASSERT_IMPL(a_shift_pos, clk, rst_n, (state_r == oqr_pkg::S_RM) && dv_r && found_r, pos_r != '0)
  `OQR_ASSERT_IMPL(a_emit_free, clk, rst_n, emit, out_free)

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int DEPTH        = 32;
  localparam int ID_W         = 16;
  localparam int RANDOM_ITEMS = 470;
  localparam int PHASE_LEN    = 50;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int STEADY_FROM  = 300;
  localparam int STEADY_TO    = 380;
  localparam int IDLE_PCT     = 31;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 10;

  localparam logic [1:0] ACT_RESERVED = 2'd3;

  typedef struct packed {
    logic [1:0]      action;
    logic [ID_W-1:0] person_id;
  } queue_cmd_t;

  typedef struct packed {
    oqr_pkg::oqr_status_t status;
    logic [ID_W-1:0]      entry_id;
    logic                 last;
  } queue_result_t;

  logic clk;
  logic rst_n;

  oqr_in_if  #(.ID_WIDTH(ID_W)) in_chan ();
  oqr_out_if #(.ID_WIDTH(ID_W)) out_chan ();

  ordered_queue_remove_by_key #(
    .DEPTH   (DEPTH),
    .ID_WIDTH(ID_W)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  queue_cmd_t      cmd_words[$];
  queue_result_t   due_results[$];

  logic [ID_W-1:0] line_ids[DEPTH];
  int              line_fill;
  int              peak_fill;
  int              n_append, n_remove, n_list, n_ignored;
  int              n_full, n_not_found, n_empty;

  int              words_in;
  int              words_out;
  int              mismatches;
  int              cycle_cnt;
  int              hold_left;
  logic            hold_done;
  logic            steady;

  logic [ID_W-1:0] id_pool[12] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h00FF, 16'hFF00,
                                   16'h1234, 16'h5555, 16'hAAAA, 16'h0F0F, 16'h7FFF, 16'h0002};

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  function automatic void push_result(oqr_pkg::oqr_status_t st, logic [ID_W-1:0] id,
                                      logic fin);
    queue_result_t r;
    r.status   = st;
    r.entry_id = id;
    r.last     = fin;
    due_results.push_back(r);
  endfunction

  // Applies one accepted word to the shadow queue and queues the words it must produce.
  function automatic void predict_queue_op(logic [1:0] act, logic [ID_W-1:0] id);
    int pos;
    pos = -1;
    case (act)
      oqr_pkg::ACT_APPEND: begin
        n_append++;
        if (line_fill >= DEPTH) begin
          n_full++;
          push_result(oqr_pkg::STAT_FULL, '0, 1'b1);
        end else begin
          line_ids[line_fill] = id;
          line_fill++;
          if (line_fill > peak_fill) peak_fill = line_fill;
          push_result(oqr_pkg::STAT_DONE, '0, 1'b1);
        end
      end
      oqr_pkg::ACT_REMOVE: begin
        n_remove++;
        for (int i = 0; i < line_fill; i++) begin
          if (pos < 0 && line_ids[i] == id) pos = i;
        end
        if (pos < 0) begin
          n_not_found++;
          push_result(oqr_pkg::STAT_NOT_FOUND, '0, 1'b1);
        end else begin
          for (int i = pos; i + 1 < line_fill; i++) line_ids[i] = line_ids[i + 1];
          line_fill--;
          push_result(oqr_pkg::STAT_DONE, '0, 1'b1);
        end
      end
      oqr_pkg::ACT_LIST: begin
        n_list++;
        if (line_fill == 0) begin
          n_empty++;
          push_result(oqr_pkg::STAT_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < line_fill; i++) begin
            push_result(oqr_pkg::STAT_ENTRY, line_ids[i], (i + 1 == line_fill));
          end
        end
      end
      default: n_ignored++;
    endcase
  endfunction

  function automatic void add_cmd(logic [1:0] act, logic [ID_W-1:0] id);
    queue_cmd_t c;
    c.action    = act;
    c.person_id = id;
    cmd_words.push_back(c);
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(99) < 60) return id_pool[$urandom_range(11)];
    return ID_W'($urandom);
  endfunction

  function automatic logic [1:0] pick_action(int pct_append, int pct_remove, int pct_list);
    int r;
    r = $urandom_range(99);
    if (r < pct_append) return oqr_pkg::ACT_APPEND;
    if (r < pct_append + pct_remove) return oqr_pkg::ACT_REMOVE;
    if (r < pct_append + pct_remove + pct_list) return oqr_pkg::ACT_LIST;
    return ACT_RESERVED;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
      steady    <= 1'b0;
    end else begin
      steady <= (words_in >= STEADY_FROM) && (words_in < STEADY_TO);
      if (!hold_done && words_in >= HOLD_AT) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  always @(posedge clk) begin : drive_words
    queue_cmd_t c;
    if (!rst_n) begin
      in_chan.valid     <= 1'b0;
      in_chan.action    <= oqr_pkg::ACT_APPEND;
      in_chan.person_id <= '0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        predict_queue_op(in_chan.action, in_chan.person_id);
        words_in <= words_in + 1;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (cmd_words.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          c = cmd_words.pop_front();
          in_chan.valid     <= 1'b1;
          in_chan.action    <= c.action;
          in_chan.person_id <= c.person_id;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_words
    queue_result_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        words_out <= words_out + 1;
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("ERROR: unexpected word status=%0d entry_id=%h last=%0b",
                     out_chan.status, out_chan.entry_id, out_chan.last);
          end
        end else begin
          want = due_results.pop_front();
          if (out_chan.status !== want.status || out_chan.entry_id !== want.entry_id ||
              out_chan.last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("ERROR: expected status=%0d entry_id=%h last=%0b, got %0d %h %0b",
                       want.status, want.entry_id, want.last,
                       out_chan.status, out_chan.entry_id, out_chan.last);
            end
          end
        end
      end
      out_chan.ready <= (hold_left == 0) && (steady || $urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : run_test
    int          random_cnt;
    int          phase;
    int          pa, pr, pl;
    logic [1:0]  act;
    cycle_cnt         = 0;
    words_in          = 0;
    words_out         = 0;
    mismatches        = 0;
    line_fill         = 0;
    peak_fill         = 0;
    n_append          = 0;
    n_remove          = 0;
    n_list            = 0;
    n_ignored         = 0;
    n_full            = 0;
    n_not_found       = 0;
    n_empty           = 0;
    rst_n             = 1'b0;

    // Empty queue, the reserved code, the only entry removed, duplicates and extreme ids.
    add_cmd(oqr_pkg::ACT_LIST, 16'hFFFF);
    add_cmd(oqr_pkg::ACT_REMOVE, 16'h0005);
    add_cmd(ACT_RESERVED, 16'hFFFF);
    add_cmd(oqr_pkg::ACT_APPEND, 16'h0000);
    add_cmd(oqr_pkg::ACT_REMOVE, 16'h0000);
    add_cmd(oqr_pkg::ACT_LIST, 16'h0000);
    add_cmd(oqr_pkg::ACT_APPEND, 16'hFFFF);
    add_cmd(oqr_pkg::ACT_APPEND, 16'h0000);
    add_cmd(oqr_pkg::ACT_APPEND, 16'h1234);
    add_cmd(oqr_pkg::ACT_APPEND, 16'hFFFF);
    add_cmd(oqr_pkg::ACT_LIST, 16'h5555);
    add_cmd(oqr_pkg::ACT_REMOVE, 16'hFFFF);
    add_cmd(oqr_pkg::ACT_LIST, 16'h0000);
    add_cmd(oqr_pkg::ACT_REMOVE, 16'h1234);
    add_cmd(oqr_pkg::ACT_REMOVE, 16'h0007);
    add_cmd(oqr_pkg::ACT_REMOVE, 16'hFFFF);
    add_cmd(oqr_pkg::ACT_LIST, 16'hAAAA);
    add_cmd(oqr_pkg::ACT_APPEND, 16'h8000);
    add_cmd(oqr_pkg::ACT_APPEND, 16'h5555);
    add_cmd(oqr_pkg::ACT_APPEND, 16'hAAAA);
    add_cmd(ACT_RESERVED, 16'h0000);
    add_cmd(oqr_pkg::ACT_LIST, 16'h0000);

    // Fill past capacity with random ids so that appends to a full queue occur, then list it.
    for (int k = 0; k < DEPTH; k++) add_cmd(oqr_pkg::ACT_APPEND, pick_id());
    add_cmd(oqr_pkg::ACT_LIST, ID_W'($urandom));
    random_cnt = cmd_words.size();

    phase = 0;
    while (random_cnt < RANDOM_ITEMS) begin
      case (phase % 3)
        0: begin pa = 75; pr = 10; pl = 10; end
        1: begin pa = 20; pr = 65; pl = 10; end
        default: begin pa = 40; pr = 35; pl = 20; end
      endcase
      for (int k = 0; k < PHASE_LEN && random_cnt < RANDOM_ITEMS; k++) begin
        act = pick_action(pa, pr, pl);
        add_cmd(act, pick_id());
        random_cnt++;
      end
      phase++;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_words.size() != 0 || in_chan.valid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d input words (%0d appends, %0d removes, %0d lists, %0d ignored)",
             words_in, n_append, n_remove, n_list, n_ignored);
    $display("and %0d result words; peak fill %0d of %0d, %0d full, %0d not found, %0d empty.",
             words_out, peak_fill, DEPTH, n_full, n_not_found, n_empty);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
